>>> src/rle_pkg.sv
// Package for the run-length scanline decoder: item types and stream constants.
package rle_pkg;

    // Low seven bits of a header byte hold the packet count
    localparam logic [7:0] COUNT_MASK   = 8'h7f;
    // Top bit of a header byte marks a literal packet
    localparam logic [7:0] LITERAL_FLAG = 8'h80;

    // Input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } in_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [15:0] repeat_count;
        logic        row_done;
        logic        status;
    } out_t;

endpackage

>>> src/rle_scanline_decoder.sv
// Run-length scanline decoder: stream bytes in, pixel runs out.
//
// Takes one compressed stream byte per clock and returns at most one pixel run per byte,
// from a result register. Header bytes of non-zero count that fit the row produce no result;
// literal bytes produce a run of one, a run value byte produces a run of the header's count,
// a zero-count header produces the zero fill for the rest of the row, and end of data or a
// packet passing row_width produces an error result that closes the row. The sustained rate is
// one item per cycle: s_ready is high whenever the result register is empty or being taken in
// the same cycle, so a stalled result holds back the input. Writing row_width abandons the
// current row and restarts decoding at a header byte; a width of zero acts as one.
module rle_scanline_decoder (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           row_width_we,
    input  logic [15:0]    row_width_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  rle_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rle_pkg::out_t  m_data
);
    import rle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_RUNVAL  = 2'd2
    } phase_t;

    logic [15:0] row_width_reg;
    phase_t      phase_reg, phase_next;
    logic [6:0]  packet_left_reg, packet_left_next;
    logic [15:0] pixels_done_reg, pixels_done_next;
    logic        m_valid_reg;
    out_t        m_data_reg;

    logic        accept;
    logic        res_valid;
    out_t        res;
    logic [16:0] eff_w;
    logic [6:0]  hdr_count;
    logic [16:0] lit_total;
    logic [16:0] run_total;
    logic [16:0] hdr_total;

    // Result register drains or is empty: take the next item
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Width of zero acts as one pixel
    assign eff_w     = (row_width_reg == 16'd0) ? 17'd1 : {1'b0, row_width_reg};
    assign hdr_count = s_data.byte_value[6:0] & COUNT_MASK[6:0];
    assign lit_total = {1'b0, pixels_done_reg} + 17'd1;
    assign run_total = {1'b0, pixels_done_reg} + {10'd0, packet_left_reg};
    assign hdr_total = {1'b0, pixels_done_reg} + {10'd0, hdr_count};

    // Per-item decode
    always_comb begin
        phase_next       = phase_reg;
        packet_left_next = packet_left_reg;
        pixels_done_next = pixels_done_reg;
        res_valid        = 1'b0;
        res              = '0;
        if (accept) begin
            if (s_data.command == CMD_END) begin
                res_valid    = 1'b1;
                res.row_done = 1'b1;
                res.status   = STATUS_ERR;
            end else begin
                case (phase_reg)
                    PH_LITERAL: begin
                        res_valid        = 1'b1;
                        res.pixel_value  = s_data.byte_value;
                        res.repeat_count = 16'd1;
                        res.row_done     = (lit_total >= eff_w);
                        res.status       = STATUS_OK;
                        pixels_done_next = lit_total[15:0];
                        packet_left_next = packet_left_reg - 7'd1;
                        if (packet_left_reg == 7'd1) begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_RUNVAL: begin
                        res_valid        = 1'b1;
                        res.pixel_value  = s_data.byte_value;
                        res.repeat_count = {9'd0, packet_left_reg};
                        res.row_done     = (run_total >= eff_w);
                        res.status       = STATUS_OK;
                        pixels_done_next = run_total[15:0];
                        packet_left_next = 7'd0;
                        phase_next       = PH_HEADER;
                    end
                    default: begin
                        if (hdr_count == 7'd0) begin
                            // End of row marker: zero fill for the remainder
                            res_valid    = 1'b1;
                            res.row_done = 1'b1;
                            res.status   = STATUS_OK;
                            if ({1'b0, pixels_done_reg} < eff_w) begin
                                res.repeat_count = 16'(eff_w - {1'b0, pixels_done_reg});
                            end
                        end else if (hdr_total > eff_w) begin
                            // Packet would overrun the row
                            res_valid    = 1'b1;
                            res.row_done = 1'b1;
                            res.status   = STATUS_ERR;
                        end else begin
                            packet_left_next = hdr_count;
                            phase_next = ((s_data.byte_value & LITERAL_FLAG) != 8'd0)
                                       ? PH_LITERAL : PH_RUNVAL;
                        end
                    end
                endcase
            end
            // Last result of a row restarts decoding
            if (res_valid && res.row_done) begin
                phase_next       = PH_HEADER;
                packet_left_next = 7'd0;
                pixels_done_next = 16'd0;
            end
        end
    end

    // State, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   <= 16'd1;
            phase_reg       <= PH_HEADER;
            packet_left_reg <= 7'd0;
            pixels_done_reg <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (row_width_we) begin
                row_width_reg   <= row_width_wdata;
                phase_reg       <= PH_HEADER;
                packet_left_reg <= 7'd0;
                pixels_done_reg <= 16'd0;
            end else begin
                phase_reg       <= phase_next;
                packet_left_reg <= packet_left_next;
                pixels_done_reg <= pixels_done_next;
            end
            if (s_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (s_ready) begin
            m_data_reg <= res;
        end
    end

    // Row position never reaches the width between items
    a_pos_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pixels_done_reg} < eff_w)
        else $error("pixel position reached row width");

    // Inside a packet the count left is non-zero and fits the row
    a_packet_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HEADER) |-> (packet_left_reg != 7'd0 && run_total <= eff_w))
        else $error("open packet does not fit row");

    // Error results close the row and carry no pixels
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_ERR) |->
        (m_data.row_done && m_data.repeat_count == 16'd0 && m_data.pixel_value == 8'd0))
        else $error("malformed error result");

    // A closed row leaves the decoder waiting for a header
    a_row_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid && res.row_done && !row_width_we) |=>
        (phase_reg == PH_HEADER && pixels_done_reg == 16'd0))
        else $error("row not restarted after last result");

endmodule
